FILE: rtl/rspa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspa_pkg
// Shared types and field widths for the refcounted slot pool allocator.
// ----------------------------------------------------------------------------
package rspa_pkg;

    localparam int ACTION_W  = 2;
    localparam int SLOT_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int REFS_W    = 4;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_RETAIN  = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_IN_USE = 2'd2,
        ST_SATURATED  = 2'd3
    } t_status;

endpackage

FILE: rtl/rspa_lowest_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspa_lowest_free
// Priority encoder: finds the lowest-numbered free slot in the pool.
// ----------------------------------------------------------------------------
module rspa_lowest_free #(
    parameter int POOL_SLOTS = 8
) (
    input  logic [POOL_SLOTS-1:0]         i_free,
    output logic                          o_found,
    output logic [$clog2(POOL_SLOTS)-1:0] o_idx
);

    localparam int IDX_W = $clog2(POOL_SLOTS);

    always_comb begin
        o_found = |i_free;
        o_idx   = '0;
        // scan downward so the lowest free slot wins
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/refcounted_slot_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_pool_allocator
// Buffer slot pool with per-slot in-use bit and reference count.
// ----------------------------------------------------------------------------
// Each transaction passes through the input register, then one pass of
// lookup/update logic into the result register.
// Throughput: one transaction per cycle while the sink accepts; slot state is
// written at the same edge the result is captured, so the next request sees it at once.
// Reset clears all in-use bits and both pipeline valids; a free slot's count
// reads as zero, so the count array itself needs no reset.
module refcounted_slot_pool_allocator #(
    parameter int POOL_SLOTS     = 8,
    parameter int REF_COUNT_BITS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [1:0] action, [4:2] slot, [7:5] zero
    input  logic [rspa_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [1:0] status, [4:2] slot_out, [5] freed, [9:6] refs_after, [15:10] zero
    output logic [rspa_pkg::M_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int SEL_W  = ((IDX_W > rspa_pkg::SLOT_W) ? IDX_W : rspa_pkg::SLOT_W) + 1;
    localparam int CNT_W  = REF_COUNT_BITS;
    localparam int CEXT_W = (CNT_W > rspa_pkg::REFS_W) ? CNT_W : rspa_pkg::REFS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // input register
    logic                          r_in_valid;
    rspa_pkg::t_action             r_in_action;
    logic [rspa_pkg::SLOT_W-1:0]   r_in_slot;

    // result register
    logic                          r_out_valid;
    rspa_pkg::t_status             r_out_status;
    logic [rspa_pkg::SLOT_W-1:0]   r_out_slot;
    logic                          r_out_freed;
    logic [rspa_pkg::REFS_W-1:0]   r_out_refs;

    // slot state
    logic [POOL_SLOTS-1:0]         r_in_use;
    logic [CNT_W-1:0]              r_cnt [POOL_SLOTS];

    logic                          w_out_free;
    logic                          w_adv;
    logic                          w_s_acc;
    logic                          w_found;
    logic [IDX_W-1:0]              w_grant;
    logic [SEL_W-1:0]              w_slot_wide;
    logic                          w_in_range;
    logic [IDX_W-1:0]              w_idx;
    logic                          w_cur_use;
    logic [CNT_W-1:0]              w_cur_cnt;

    rspa_pkg::t_status             n_status;
    logic [SEL_W-1:0]              n_slot;
    logic                          n_freed;
    logic [CNT_W-1:0]              n_refs;
    logic                          n_wr_en;
    logic [IDX_W-1:0]              n_wr_idx;
    logic [CNT_W-1:0]              n_wr_cnt;
    logic                          n_set_use;
    logic                          n_clr_use;
    logic [CEXT_W-1:0]             w_refs_ext;
    logic [POOL_SLOTS-1:0]         w_cnt_nz;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    rspa_lowest_free #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_lowest_free (
        .i_free  (~r_in_use),
        .o_found (w_found),
        .o_idx   (w_grant)
    );

    assign w_slot_wide = SEL_W'(r_in_slot);
    assign w_in_range  = w_slot_wide < SEL_W'(POOL_SLOTS);
    assign w_idx       = w_slot_wide[IDX_W-1:0];
    assign w_cur_use   = w_in_range && r_in_use[w_idx];
    assign w_cur_cnt   = w_cur_use ? r_cnt[w_idx] : '0;

    always_comb begin
        n_status  = rspa_pkg::ST_OK;
        n_slot    = w_slot_wide;
        n_freed   = 1'b0;
        n_refs    = '0;
        n_wr_en   = 1'b0;
        n_wr_idx  = w_idx;
        n_wr_cnt  = '0;
        n_set_use = 1'b0;
        n_clr_use = 1'b0;
        unique case (r_in_action)
            rspa_pkg::ACT_ACQUIRE: begin
                if (w_found) begin
                    n_slot    = SEL_W'(w_grant);
                    n_refs    = CNT_ONE;
                    n_wr_en   = 1'b1;
                    n_wr_idx  = w_grant;
                    n_wr_cnt  = CNT_ONE;
                    n_set_use = 1'b1;
                end else begin
                    n_status = rspa_pkg::ST_EXHAUSTED;
                    n_slot   = '0;
                end
            end
            rspa_pkg::ACT_RELEASE: begin
                if (!w_cur_use) begin
                    n_status = rspa_pkg::ST_NOT_IN_USE;
                end else begin
                    // an in-use slot always holds at least one reference
                    n_wr_en  = 1'b1;
                    n_wr_cnt = w_cur_cnt - CNT_ONE;
                    if (w_cur_cnt == CNT_ONE) begin
                        n_clr_use = 1'b1;
                        n_freed   = 1'b1;
                    end else begin
                        n_refs = w_cur_cnt - CNT_ONE;
                    end
                end
            end
            rspa_pkg::ACT_RETAIN: begin
                if (!w_cur_use) begin
                    n_status = rspa_pkg::ST_NOT_IN_USE;
                end else if (w_cur_cnt == CNT_MAX) begin
                    n_status = rspa_pkg::ST_SATURATED;
                    n_refs   = CNT_MAX;
                end else begin
                    n_wr_en  = 1'b1;
                    n_wr_cnt = w_cur_cnt + CNT_ONE;
                    n_refs   = w_cur_cnt + CNT_ONE;
                end
            end
            rspa_pkg::ACT_NOP: begin
                n_refs = w_cur_cnt;
            end
            default: begin
                n_status = rspa_pkg::ST_OK;
            end
        endcase
    end

    assign w_refs_ext = CEXT_W'(n_refs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_use    <= '0;
        end else begin
            if (w_s_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv && n_set_use) begin
                r_in_use[n_wr_idx] <= 1'b1;
            end else if (w_adv && n_clr_use) begin
                r_in_use[n_wr_idx] <= 1'b0;
            end
        end
    end

    // payload registers and count array
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_action <= rspa_pkg::t_action'(i_s_tdata[1:0]);
            r_in_slot   <= i_s_tdata[4:2];
        end
        if (w_adv) begin
            r_out_status <= n_status;
            r_out_slot   <= n_slot[rspa_pkg::SLOT_W-1:0];
            r_out_freed  <= n_freed;
            r_out_refs   <= w_refs_ext[rspa_pkg::REFS_W-1:0];
            if (n_wr_en) begin
                r_cnt[n_wr_idx] <= n_wr_cnt;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_refs, r_out_freed, r_out_slot, r_out_status};

    always_comb begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
            w_cnt_nz[i] = (r_cnt[i] != '0);
        end
    end

    // every slot in use carries at least one reference
    a_use_has_refs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_use & ~w_cnt_nz) == '0)
        else $error("in-use slot with zero reference count");

    // a granted slot is marked in use right after the grant
    a_grant_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_action == rspa_pkg::ACT_ACQUIRE && w_found)
        |=> r_in_use[$past(w_grant)])
        else $error("granted slot not marked in use");

    // exhausted only when every slot is taken
    a_exhaust_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_status == rspa_pkg::ST_EXHAUSTED) |-> (&r_in_use))
        else $error("pool reported exhausted with a free slot");

    // a freed result clears the slot's in-use bit
    a_free_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_freed) |=> !r_in_use[$past(n_wr_idx)])
        else $error("freed slot still marked in use");

endmodule

FILE: verif/refcounted_slot_pool_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_pool_allocator_tb
// Self-checking bench for the slot pool allocator. A queue of requests
// (acquire, release, retain, unused code) feeds a bursty stream driver; a
// shadow copy of the pool predicts each reply at the input transaction and
// the monitor checks replies in order while the sink stalls on its own
// pattern. Directed requests cover exhaustion, saturation, freeing and
// requests on free slots; random phases then fill, pump and drain the pool.
// ----------------------------------------------------------------------------
module refcounted_slot_pool_allocator_tb;

    localparam int POOL       = 8;
    localparam int COUNT_BITS = 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int RANDOM_REQS = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_AT = 300;  // requests taken before the long sink stall
    localparam int DRAIN_AT    = 700;  // requests taken before the sender drains

    typedef struct {
        rspa_pkg::t_action           act;
        logic [rspa_pkg::SLOT_W-1:0] slot;
    } t_pool_req;

    typedef struct {
        rspa_pkg::t_status           status;
        logic [rspa_pkg::SLOT_W-1:0] slot_out;
        logic                        freed;
        logic [rspa_pkg::REFS_W-1:0] refs;
    } t_pool_reply;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    // [1:0] action, [4:2] slot, [7:5] zero
    logic [rspa_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    // [1:0] status, [4:2] slot_out, [5] freed, [9:6] refs_after, [15:10] zero
    logic [rspa_pkg::M_TDATA_W-1:0] o_m_tdata;

    refcounted_slot_pool_allocator #(
        .POOL_SLOTS    (POOL),
        .REF_COUNT_BITS(COUNT_BITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Shadow pool
    bit                    slot_busy [POOL];
    logic [COUNT_BITS-1:0] slot_refs [POOL] = '{default: '0};

    t_pool_req   request_q[$];
    t_pool_reply reply_q[$];

    int  reqs_taken     = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  req_took       = 1'b0;
    bit  drain_wait     = 1'b0;
    bit  hold_off_done  = 1'b0;
    int  hold_off_left  = 0;
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  sink_mode      = 0;
    int  sink_mode_left = 0;
    int  sink_phase     = 0;

    function automatic t_pool_reply apply_request(t_pool_req req);
        t_pool_reply r;
        int          idx;
        bit          found;
        r.status   = rspa_pkg::ST_OK;
        r.slot_out = req.slot;
        r.freed    = 1'b0;
        r.refs     = '0;
        idx        = int'(req.slot);
        found      = 1'b0;
        case (req.act)
            rspa_pkg::ACT_ACQUIRE: begin
                r.status   = rspa_pkg::ST_EXHAUSTED;
                r.slot_out = '0;
                for (int i = 0; i < POOL; i++) begin
                    if (!found && !slot_busy[i]) begin
                        found        = 1'b1;
                        slot_busy[i] = 1'b1;
                        slot_refs[i] = COUNT_BITS'(1);
                        r.status     = rspa_pkg::ST_OK;
                        r.slot_out   = rspa_pkg::SLOT_W'(i);
                        r.refs       = rspa_pkg::REFS_W'(1);
                    end
                end
            end
            rspa_pkg::ACT_RELEASE, rspa_pkg::ACT_RETAIN: begin
                if (idx >= POOL || !slot_busy[idx]) begin
                    r.status = rspa_pkg::ST_NOT_IN_USE;
                end else if (req.act == rspa_pkg::ACT_RETAIN) begin
                    if (slot_refs[idx] == COUNT_MAX) begin
                        r.status = rspa_pkg::ST_SATURATED;
                        r.refs   = rspa_pkg::REFS_W'(COUNT_MAX);
                    end else begin
                        slot_refs[idx] = slot_refs[idx] + 1'b1;
                        r.refs         = rspa_pkg::REFS_W'(slot_refs[idx]);
                    end
                end else begin
                    if (slot_refs[idx] != 0)
                        slot_refs[idx] = slot_refs[idx] - 1'b1;
                    if (slot_refs[idx] == 0) begin
                        slot_busy[idx] = 1'b0;
                        r.freed        = 1'b1;
                    end else begin
                        r.refs = rspa_pkg::REFS_W'(slot_refs[idx]);
                    end
                end
            end
            default: begin
                // unused code: no state change, reports the current count
                r.refs = (idx < POOL) ? rspa_pkg::REFS_W'(slot_refs[idx]) : '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d",
                 $realtime, field, got, want);
    endtask

    task automatic check_reply(logic [rspa_pkg::M_TDATA_W-1:0] data);
        t_pool_reply want;
        if (reply_q.size() == 0) begin
            report_mismatch("unexpected reply", int'(data), 0);
        end else begin
            want = reply_q.pop_front();
            if (data[1:0] != want.status)
                report_mismatch("status", int'(data[1:0]), int'(want.status));
            if (data[4:2] != want.slot_out)
                report_mismatch("slot_out", int'(data[4:2]), int'(want.slot_out));
            if (data[5] != want.freed)
                report_mismatch("freed", int'(data[5]), int'(want.freed));
            if (data[9:6] != want.refs)
                report_mismatch("refs_after", int'(data[9:6]), int'(want.refs));
        end
    endtask

    task automatic push_req(rspa_pkg::t_action act, int slot);
        t_pool_req req;
        req.act  = act;
        req.slot = rspa_pkg::SLOT_W'(slot);
        request_q.push_back(req);
    endtask

    // Monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        t_pool_req req;
        if (i_rst_n) begin
            cycle_count++;
            if (o_m_tvalid && i_m_tready)
                check_reply(o_m_tdata);
            if (i_s_tvalid && o_s_tready) begin
                req = request_q.pop_front();
                reply_q.push_back(apply_request(req));
                reqs_taken++;
                req_took = 1'b1;
                if (reqs_taken == DRAIN_AT)
                    drain_wait = 1'b1;
            end
        end
    end

    // Driver: bursts of requests with random gaps, valid held until taken
    always @(negedge i_clk) begin
        bit holding;
        holding  = i_s_tvalid && !req_took;
        req_took = 1'b0;
        if (drain_wait && reply_q.size() == 0)
            drain_wait = 1'b0;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (holding) begin
            i_s_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            i_s_tvalid <= 1'b0;
        end else if (drain_wait || request_q.size() == 0) begin
            i_s_tvalid <= 1'b0;
        end else begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {3'b000, request_q[0].slot, request_q[0].act};
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 40);
                case ($urandom_range(0, 3))
                    0, 1:    gap_left = 0;
                    2:       gap_left = $urandom_range(1, 4);
                    default: gap_left = $urandom_range(5, 20);
                endcase
            end
        end
    end

    // Sink: stall pattern switches at random, one long hold-off
    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = $urandom_range(0, 3);
            sink_mode_left = $urandom_range(20, 80);
        end
        sink_mode_left--;
        sink_phase = (sink_phase + 1) % 5;
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_m_tready <= 1'b0;
        end else if (!hold_off_done && reqs_taken >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            hold_off_left = 150;
            i_m_tready <= 1'b0;
        end else begin
            case (sink_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 9) < 7);
                2:       i_m_tready <= (sink_phase < 3);
                default: i_m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int n;
        int len;
        int hot;
        int pick;
        int w_acq;
        int w_rel;

        // Directed: fill the pool, hit exhaustion, saturate one slot
        for (int i = 0; i <= POOL; i++)
            push_req(rspa_pkg::ACT_ACQUIRE, 7);
        for (int i = 0; i < 15; i++)
            push_req(rspa_pkg::ACT_RETAIN, 5);
        push_req(rspa_pkg::ACT_NOP, 5);
        push_req(rspa_pkg::ACT_RELEASE, 5);
        // freeing a slot, then requests on the now free slot
        push_req(rspa_pkg::ACT_RELEASE, 3);
        push_req(rspa_pkg::ACT_RELEASE, 3);
        push_req(rspa_pkg::ACT_RETAIN, 3);
        push_req(rspa_pkg::ACT_NOP, 3);
        push_req(rspa_pkg::ACT_ACQUIRE, 0);

        // Random phases: fill, pump one slot, drain, or mixed traffic
        n = 0;
        while (n < RANDOM_REQS) begin
            len = $urandom_range(10, 60);
            hot = $urandom_range(0, POOL - 1);
            case ($urandom_range(0, 3))
                0:       begin w_acq = 70; w_rel = 15; end
                1:       begin w_acq = 10; w_rel = 75; end
                2:       begin w_acq = 35; w_rel = 35; end
                default: begin w_acq = 5;  w_rel = 5;  end  // mostly retains
            endcase
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 24) == 0)
                    push_req(rspa_pkg::ACT_NOP, $urandom_range(0, 7));
                else if (pick < w_acq)
                    push_req(rspa_pkg::ACT_ACQUIRE, $urandom_range(0, 7));
                else if (pick < w_acq + w_rel)
                    push_req(rspa_pkg::ACT_RELEASE, ($urandom_range(0, 1)) ? hot
                                                              : $urandom_range(0, 7));
                else
                    push_req(rspa_pkg::ACT_RETAIN, ($urandom_range(0, 3) != 0) ? hot
                                                                  : $urandom_range(0, 7));
            end
            n += len;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (request_q.size() == 0);
        wait (reply_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (reply_q.size() != 0)
            report_mismatch("replies left over", reply_q.size(), 0);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
